[src/pdu_pkg.sv]
// Shared types, codes and helpers for the percent decoder with UTF-8 check.
package pdu_pkg;

	localparam logic [7:0] PERCENT_CHAR = 8'h25;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_ESCAPE = 2'd1;
	localparam logic [1:0] ST_BAD_UTF8   = 2'd2;

	// one source byte of the encoded string
	typedef struct packed {
		logic [7:0] in_byte;
		logic       last;
	} src_item_t;

	// one result item
	typedef struct packed {
		logic       has_byte;
		logic [7:0] out_byte;
		logic       done_res;
		logic [1:0] status;
	} dst_item_t;

	// decoded item handed from the front to the back
	typedef struct packed {
		logic       has_byte;
		logic [7:0] dec_byte;
		logic       last;
		logic       esc_err;   // escape status of the string, on last only
	} mid_item_t;

	// 0..15 for a hex digit of either case, 16 otherwise
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'd16;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 5'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 5'(c - 8'h41 + 8'd10);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = 5'(c - 8'h61 + 8'd10);
		end
		return v;
	endfunction

endpackage

[src/pdu_front.sv]
// Front end: percent-escape decoding of the source bytes.
module pdu_front import pdu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  src_item_t src,
	input  logic      take,
	output mid_item_t mid
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ONE,
		PH_TWO
	} phase_t;

	phase_t     phase_q, phase_n;
	logic [3:0] nib_q, nib_n;
	logic       err_q, err_n;
	logic [4:0] hv;

	always_comb begin
		hv           = hex_value(src.in_byte);
		phase_n      = phase_q;
		nib_n        = nib_q;
		err_n        = err_q;
		mid.has_byte = 1'b0;
		mid.dec_byte = 8'h00;
		mid.last     = src.last;
		mid.esc_err  = 1'b0;
		if (!err_q) begin
			case (phase_q)
				PH_IDLE: begin
					if (src.in_byte == PERCENT_CHAR) begin
						phase_n = PH_ONE;
					end else begin
						mid.has_byte = 1'b1;
						mid.dec_byte = src.in_byte;
					end
				end
				PH_ONE: begin
					if (hv[4]) begin
						err_n   = 1'b1;
						phase_n = PH_IDLE;
					end else begin
						nib_n   = hv[3:0];
						phase_n = PH_TWO;
					end
				end
				PH_TWO: begin
					if (hv[4]) begin
						err_n   = 1'b1;
						phase_n = PH_IDLE;
					end else begin
						mid.has_byte = 1'b1;
						mid.dec_byte = {nib_q, hv[3:0]};
						nib_n        = 4'h0;
						phase_n      = PH_IDLE;
					end
				end
				default: begin
					phase_n = PH_IDLE;
				end
			endcase
		end
		if (src.last) begin
			// unfinished escape at the end counts as bad
			mid.esc_err = err_n | (phase_n != PH_IDLE);
			phase_n     = PH_IDLE;
			nib_n       = 4'h0;
			err_n       = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			nib_q   <= 4'h0;
			err_q   <= 1'b0;
		end else if (take) begin
			phase_q <= phase_n;
			nib_q   <= nib_n;
			err_q   <= err_n;
		end
	end

endmodule

[src/pdu_queue.sv]
// Short register queue between the decoder front and the UTF-8 back end.
module pdu_queue import pdu_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  mid_item_t wr_item,
	output logic      full,
	input  logic      pop,
	output mid_item_t rd_item,
	output logic      avail
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mid_item_t        slot_q [DEPTH];
	logic [IW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign avail   = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && avail;
	assign rd_item = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == IW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == IW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/pdu_back.sv]
// Back end: RFC 3629 UTF-8 check of decoded bytes and result register.
module pdu_back import pdu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  mid_item_t mid,
	input  logic      avail,
	output logic      pop,
	output logic      dst_valid,
	input  logic      dst_stall,
	output dst_item_t dst
);

	typedef enum logic [2:0] {
		RULE_ANY,
		RULE_A0_BF,
		RULE_80_9F,
		RULE_90_BF,
		RULE_80_8F
	} rule_t;

	logic [1:0] pend_q, pend_n;
	rule_t      rule_q, rule_n;
	logic       uerr_q, uerr_n;
	logic [7:0] lo, hi, b;
	logic       vld_q;
	dst_item_t  res_q, res_n;

	assign pop       = avail && (!vld_q || !dst_stall);
	assign dst_valid = vld_q;
	assign dst       = res_q;
	assign b         = mid.dec_byte;

	always_comb begin
		pend_n = pend_q;
		rule_n = rule_q;
		uerr_n = uerr_q;
		lo     = 8'h80;
		hi     = 8'hBF;
		case (rule_q)
			RULE_A0_BF: lo = 8'hA0;
			RULE_80_9F: hi = 8'h9F;
			RULE_90_BF: lo = 8'h90;
			RULE_80_8F: hi = 8'h8F;
			default:    lo = 8'h80;
		endcase
		if (mid.has_byte && !uerr_q) begin
			if (pend_q != 2'd0) begin
				if (b < lo || b > hi) begin
					uerr_n = 1'b1;
				end else begin
					rule_n = RULE_ANY;
					pend_n = pend_q - 2'd1;
				end
			end else if (b <= 8'h7F) begin
				pend_n = 2'd0;
			end else if (b >= 8'hC2 && b <= 8'hDF) begin
				pend_n = 2'd1;
				rule_n = RULE_ANY;
			end else if (b == 8'hE0) begin
				pend_n = 2'd2;
				rule_n = RULE_A0_BF;
			end else if (b == 8'hED) begin
				pend_n = 2'd2;
				rule_n = RULE_80_9F;
			end else if (b >= 8'hE1 && b <= 8'hEF) begin
				pend_n = 2'd2;
				rule_n = RULE_ANY;
			end else if (b == 8'hF0) begin
				pend_n = 2'd3;
				rule_n = RULE_90_BF;
			end else if (b >= 8'hF1 && b <= 8'hF3) begin
				pend_n = 2'd3;
				rule_n = RULE_ANY;
			end else if (b == 8'hF4) begin
				pend_n = 2'd3;
				rule_n = RULE_80_8F;
			end else begin
				uerr_n = 1'b1;
			end
		end
		res_n.has_byte = mid.has_byte;
		res_n.out_byte = mid.has_byte ? mid.dec_byte : 8'h00;
		res_n.done_res = mid.last;
		res_n.status   = ST_OK;
		if (mid.last) begin
			if (mid.esc_err) begin
				res_n.status = ST_BAD_ESCAPE;
			end else if (uerr_n || pend_n != 2'd0) begin
				res_n.status = ST_BAD_UTF8;
			end
			pend_n = 2'd0;
			rule_n = RULE_ANY;
			uerr_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			rule_q <= RULE_ANY;
			uerr_q <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (pop) begin
				pend_q <= pend_n;
				rule_q <= rule_n;
				uerr_q <= uerr_n;
				vld_q  <= 1'b1;
			end else if (!dst_stall) begin
				vld_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_n;
		end
	end

endmodule

[src/percent_decode_utf8_check.sv]
// Top level: percent decoder with UTF-8 validation, front, queue and back.
// Path: an accepted item is written into the queue, then popped into the result register that drives dst.
// Throughput: one item per cycle while the queue has room; the queue decouples decode from the check.
// Input stall rises only when the queue holds DEPTH items (output held off).
// Reset (arst_n low) clears escape and UTF-8 state, empties the queue and drops dst_valid.
module percent_decode_utf8_check import pdu_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  src_item_t src,
	output logic      dst_valid,
	input  logic      dst_stall,
	output dst_item_t dst
);

	mid_item_t front_item;   // decoded item from the front, this cycle
	mid_item_t queue_item;   // oldest item in the queue
	logic      q_full;
	logic      q_avail;
	logic      q_pop;
	logic      take;

	// an item is taken whenever the queue has room
	assign src_stall = q_full;
	assign take      = src_valid && !q_full;

	// front: escape decoding, swallowing after a bad escape
	pdu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.take   (take),
		.mid    (front_item)
	);

	// queue: lets the output side stall without blocking the decoder at once
	pdu_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (take),
		.wr_item (front_item),
		.full    (q_full),
		.pop     (q_pop),
		.rd_item (queue_item),
		.avail   (q_avail)
	);

	// back: UTF-8 check, final status, output register
	pdu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid       (queue_item),
		.avail     (q_avail),
		.pop       (q_pop),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst       (dst)
	);

	// status is only reported on the last item of a string
	a_status_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst.done_res |-> dst.status == ST_OK)
		else $error("status set on an item that is not last");

	// a bad escape swallows everything, so its final item carries no byte
	a_escape_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst.status == ST_BAD_ESCAPE |-> !dst.has_byte)
		else $error("byte emitted with escape error status");

	// out_byte is zero when no byte is carried
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst.has_byte |-> dst.out_byte == 8'h00)
		else $error("out_byte nonzero without has_byte");

	// the input side only stalls when the result side is holding off
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> q_avail && dst_valid)
		else $error("input stalled while output side is free");

endmodule

[bench/decode_checker.sv]
// Checker for the percent decoder: predicts each result item and compares it on dst.
module decode_checker import pdu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	input  logic      src_stall,
	input  src_item_t src,
	input  logic      dst_valid,
	input  logic      dst_stall,
	input  dst_item_t dst,
	output int        mismatches,
	output int        in_flight,
	output int        n_ok,
	output int        n_bad_escape,
	output int        n_bad_utf8
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ESC_NONE      = 2'd0;
	localparam logic [1:0] ESC_AFTER_PCT = 2'd1;
	localparam logic [1:0] ESC_AFTER_HI  = 2'd2;

	localparam logic [2:0] CONT_80_BF = 3'd0;
	localparam logic [2:0] CONT_A0_BF = 3'd1;
	localparam logic [2:0] CONT_80_9F = 3'd2;
	localparam logic [2:0] CONT_90_BF = 3'd3;
	localparam logic [2:0] CONT_80_8F = 3'd4;

	logic [1:0] esc_state;
	logic [3:0] hi_nib;
	logic [1:0] cont_left;
	logic [2:0] cont_rule;
	logic [1:0] str_err;

	dst_item_t decoded_fifo[$];

	// 0..15 for a hex digit, bit 4 set otherwise
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
		if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h37);
		if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h57);
		return 5'h10;
	endfunction

	function automatic void clear_string();
		esc_state = ESC_NONE;
		hi_nib    = 4'h0;
		cont_left = 2'd0;
		cont_rule = CONT_80_BF;
		str_err   = ST_OK;
	endfunction

	// RFC 3629 tracking; first error sticks, checking stops after it
	function automatic void utf8_track(input logic [7:0] b);
		logic [7:0] lo, hi;
		lo = 8'h80;
		hi = 8'hBF;
		if (str_err != ST_OK) return;
		if (cont_left != 2'd0) begin
			case (cont_rule)
				CONT_A0_BF: lo = 8'hA0;
				CONT_80_9F: hi = 8'h9F;
				CONT_90_BF: lo = 8'h90;
				CONT_80_8F: hi = 8'h8F;
				default: ;
			endcase
			if (b < lo || b > hi) begin
				str_err = ST_BAD_UTF8;
			end else begin
				cont_rule = CONT_80_BF;
				cont_left = cont_left - 2'd1;
			end
		end else if (b <= 8'h7F) begin
		end else if (b >= 8'hC2 && b <= 8'hDF) begin
			cont_left = 2'd1; cont_rule = CONT_80_BF;
		end else if (b == 8'hE0) begin
			cont_left = 2'd2; cont_rule = CONT_A0_BF;
		end else if (b == 8'hED) begin
			cont_left = 2'd2; cont_rule = CONT_80_9F;
		end else if (b >= 8'hE1 && b <= 8'hEF) begin
			cont_left = 2'd2; cont_rule = CONT_80_BF;
		end else if (b == 8'hF0) begin
			cont_left = 2'd3; cont_rule = CONT_90_BF;
		end else if (b >= 8'hF1 && b <= 8'hF3) begin
			cont_left = 2'd3; cont_rule = CONT_80_BF;
		end else if (b == 8'hF4) begin
			cont_left = 2'd3; cont_rule = CONT_80_8F;
		end else begin
			str_err = ST_BAD_UTF8;
		end
	endfunction

	function automatic dst_item_t decode_step(input src_item_t it);
		dst_item_t  r;
		logic [4:0] nib;
		r   = '0;
		nib = nibble_of(it.in_byte);
		// after an escape error the rest of the string is swallowed
		if (str_err != ST_BAD_ESCAPE) begin
			if (esc_state == ESC_NONE) begin
				if (it.in_byte == PERCENT_CHAR) begin
					esc_state = ESC_AFTER_PCT;
				end else begin
					r.has_byte = 1'b1;
					r.out_byte = it.in_byte;
				end
			end else if (nib[4]) begin
				str_err   = ST_BAD_ESCAPE;
				esc_state = ESC_NONE;
			end else if (esc_state == ESC_AFTER_PCT) begin
				hi_nib    = nib[3:0];
				esc_state = ESC_AFTER_HI;
			end else begin
				r.has_byte = 1'b1;
				r.out_byte = {hi_nib, nib[3:0]};
				esc_state  = ESC_NONE;
				hi_nib     = 4'h0;
			end
			if (r.has_byte) utf8_track(r.out_byte);
		end
		if (it.last) begin
			if (esc_state != ESC_NONE) str_err = ST_BAD_ESCAPE;
			if (cont_left != 2'd0 && str_err == ST_OK) str_err = ST_BAD_UTF8;
			r.done_res = 1'b1;
			r.status   = str_err;
			clear_string();
		end
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want_v, got_v);
		if (want_v != got_v) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		dst_item_t want;
		if (!arst_n) begin
			clear_string();
			decoded_fifo.delete();
			mismatches   = 0;
			n_ok         = 0;
			n_bad_escape = 0;
			n_bad_utf8   = 0;
			in_flight   <= 0;
		end else begin
			if (dst_valid && !dst_stall) begin
				if (decoded_fifo.size() == 0) begin
					$error("unexpected result item %p", dst);
					mismatches++;
				end else begin
					want = decoded_fifo.pop_front();
					check_field("has_byte", want.has_byte, dst.has_byte);
					check_field("out_byte", want.out_byte, dst.out_byte);
					check_field("done_res", want.done_res, dst.done_res);
					check_field("status", want.status, dst.status);
					if (want.done_res) begin
						case (want.status)
							ST_OK:         n_ok++;
							ST_BAD_ESCAPE: n_bad_escape++;
							default:       n_bad_utf8++;
						endcase
					end
				end
			end
			if (src_valid && !src_stall) begin
				decoded_fifo.insert(decoded_fifo.size(), decode_step(src));
			end
			in_flight <= decoded_fifo.size();
		end
	end

endmodule

[bench/tb_top.sv]
// Testbench top for the percent decoder: clock, reset, stimulus, receiver and verdict.
module tb_top import pdu_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 1000;
	localparam int FLOOD_HOLD  = 64;      // long output hold-off, in cycles
	localparam int CYCLE_LIMIT = 400000;  // far above the slowest legal run

	logic      clk;
	logic      arst_n;
	logic      src_valid;
	logic      src_stall;
	src_item_t src;
	logic      dst_valid;
	logic      dst_stall;
	dst_item_t dst;

	// handshake between stimulus and receiver for the long hold-off
	logic flood_req;
	logic flood_ack;

	int mismatches, in_flight, n_ok, n_bad_escape, n_bad_utf8;
	int items_sent;
	int burst_left;
	int cycle_count;

	logic [7:0] plain_q[$];  // decoded bytes of the string being built
	logic [7:0] enc_q[$];    // its percent-encoded form

	percent_decode_utf8_check uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src       (src),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst       (dst)
	);

	decode_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_stall    (src_stall),
		.src          (src),
		.dst_valid    (dst_valid),
		.dst_stall    (dst_stall),
		.dst          (dst),
		.mismatches   (mismatches),
		.in_flight    (in_flight),
		.n_ok         (n_ok),
		.n_bad_escape (n_bad_escape),
		.n_bad_utf8   (n_bad_utf8)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d results outstanding", cycle_count, in_flight);
		$display("Regression FAIL");
		$finish;
	end

	// Receiver: stall pattern of its own, in runs of random length and density.
	// Runs with no stall at all alternate with heavy and fully blocked stretches.
	// When the stimulus raises flood_req, hold dst off so the internal queue
	// fills and src_stall has to rise, then answer with flood_ack.
	initial begin
		int sel, pct, run;
		dst_stall <= 1'b0;
		flood_ack <= 1'b0;
		forever begin
			sel = $urandom_range(0, 9);
			run = $urandom_range(5, 80);
			if (sel <= 2) pct = 0;
			else if (sel <= 4) pct = 20;
			else if (sel <= 6) pct = 50;
			else if (sel <= 8) pct = 85;
			else begin
				pct = 100;
				run = $urandom_range(20, 60);
			end
			repeat (run) begin
				@(posedge clk);
				if (flood_req && !flood_ack) begin
					dst_stall <= 1'b1;
					repeat (FLOOD_HOLD) @(posedge clk);
					flood_ack <= 1'b1;
				end
				dst_stall <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	// Offer one source byte and hold it until accepted. The sender runs in
	// bursts; at the end of a burst it may drop valid for a random gap, which
	// lands anywhere inside a string, escapes included. No gaps during the flood.
	task automatic send_byte(input logic [7:0] b, input logic lst);
		int gap;
		src       <= '{in_byte: b, last: lst};
		src_valid <= 1'b1;
		do @(posedge clk); while (src_stall);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else if (!(flood_req && !flood_ack)) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				src_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, 24);
		end
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
	endtask

	// Stop offering and wait until every predicted result has come back.
	// in_flight is updated at the edge, so it is read only after an edge has passed.
	task automatic wait_drain();
		src_valid <= 1'b0;
		do @(posedge clk); while (in_flight != 0);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'(8'h30 + n);
		// either case is legal
		return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 4'd10);
	endfunction

	// append one byte to the decoded or to the encoded string
	function automatic void add_plain(input logic [7:0] b);
		plain_q.insert(plain_q.size(), b);
	endfunction

	function automatic void add_enc(input logic [7:0] b);
		enc_q.insert(enc_q.size(), b);
	endfunction

	// Append one scalar value as UTF-8. Classes by encoded length, with the
	// range edges and the surrogate borders picked now and then.
	task automatic add_code_point();
		int unsigned lo, hi, cp;
		case ($urandom_range(0, 3))
			0:       begin lo = 'h0;     hi = 'h7F;     end
			1:       begin lo = 'h80;    hi = 'h7FF;    end
			2:       begin lo = 'h800;   hi = 'hFFFF;   end
			default: begin lo = 'h10000; hi = 'h10FFFF; end
		endcase
		if ($urandom_range(0, 3) == 0) cp = $urandom_range(0, 1) ? lo : hi;
		else cp = $urandom_range(hi, lo);
		if (cp >= 'hD800 && cp <= 'hDFFF) cp = $urandom_range(0, 1) ? 'hD7FF : 'hE000;
		if (cp < 'h80) begin
			add_plain(8'(cp));
		end else if (cp < 'h800) begin
			add_plain(8'('hC0 | (cp >> 6)));
			add_plain(8'('h80 | (cp & 'h3F)));
		end else if (cp < 'h10000) begin
			add_plain(8'('hE0 | (cp >> 12)));
			add_plain(8'('h80 | ((cp >> 6) & 'h3F)));
			add_plain(8'('h80 | (cp & 'h3F)));
		end else begin
			add_plain(8'('hF0 | (cp >> 18)));
			add_plain(8'('h80 | ((cp >> 12) & 'h3F)));
			add_plain(8'('h80 | ((cp >> 6) & 'h3F)));
			add_plain(8'('h80 | (cp & 'h3F)));
		end
	endtask

	// Most strings are valid UTF-8, percent-encoded byte by byte at random
	// ('%' itself always escaped). The rest are damaged: a byte overwritten,
	// the tail cut off (may leave an escape or a sequence open), a stray '%'
	// slipped in, or pure noise bytes.
	task automatic send_random_string();
		int kind, pos, k;
		plain_q.delete();
		enc_q.delete();
		repeat ($urandom_range(1, 6)) add_code_point();
		foreach (plain_q[i]) begin
			if (plain_q[i] == PERCENT_CHAR || $urandom_range(0, 2) == 0) begin
				add_enc(PERCENT_CHAR);
				add_enc(hex_char(plain_q[i][7:4]));
				add_enc(hex_char(plain_q[i][3:0]));
			end else begin
				add_enc(plain_q[i]);
			end
		end
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
		end else if (kind < 78) begin
			pos = $urandom_range(0, enc_q.size() - 1);
			enc_q[pos] = 8'($urandom_range(0, 255));
		end else if (kind < 84) begin
			k = $urandom_range(1, enc_q.size());
			while (enc_q.size() > k) void'(enc_q.pop_back());
		end else if (kind < 90) begin
			pos = $urandom_range(0, enc_q.size());
			enc_q.insert(pos, PERCENT_CHAR);
		end else begin
			enc_q.delete();
			repeat ($urandom_range(1, 8)) add_enc(8'($urandom_range(0, 255)));
		end
		foreach (enc_q[i]) send_byte(enc_q[i], i == enc_q.size() - 1);
	endtask

	initial begin
		logic flood_done;
		logic mid_drain_done;
		src_valid  <= 1'b0;
		src        <= '0;
		flood_req  <= 1'b0;
		arst_n     <= 1'b0;
		items_sent = 0;
		burst_left = 0;
		flood_done = 1'b0;
		mid_drain_done = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed strings, octal escapes for raw high bytes:
		// NUL and 0xFF as whole strings (0xFF is never a legal lead),
		send_byte(8'h00, 1'b1);
		send_str("\377");
		// escapes in lower case decoding to 'J' and a two-byte sequence
		// finished by a raw continuation byte,
		send_str("%4a%c3\251");
		// '%' after '%', a non-hex digit with the rest swallowed,
		send_str("%%");
		send_str("%GA");
		// escapes cut short by the end of the string,
		send_str("%");
		send_str("%F");
		// continuation below the E0 range, a lead where a continuation
		// belongs, a sequence cut off at the end, F4 above U+10FFFF.
		send_str("\340\200");
		send_str("\303\303");
		send_str("\342\202");
		send_str("\364\220");
		wait_drain();

		// Random part; once in the middle the output is held off while the
		// sender keeps going, and once the sender waits for a full drain.
		while (items_sent < ITEM_TARGET) begin
			if (!flood_done && items_sent >= ITEM_TARGET * 2 / 5) begin
				flood_req <= 1'b1;
				@(posedge clk);
				while (!flood_ack) send_random_string();
				flood_done = 1'b1;
				wait_drain();
			end
			if (!mid_drain_done && items_sent >= ITEM_TARGET * 7 / 10) begin
				mid_drain_done = 1'b1;
				wait_drain();
			end
			send_random_string();
		end

		wait_drain();
		repeat (10) @(posedge clk);
		$display("Sent %0d source bytes, with a %0d-cycle output hold-off and random gaps.",
			items_sent, FLOOD_HOLD);
		$display("Strings checked: %0d ok, %0d bad escape, %0d bad UTF-8; %0d mismatches.",
			n_ok, n_bad_escape, n_bad_utf8, mismatches);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

[sim.f]
src/pdu_pkg.sv
src/pdu_front.sv
src/pdu_queue.sv
src/pdu_back.sv
src/percent_decode_utf8_check.sv
bench/decode_checker.sv
bench/tb_top.sv
